### rtl/lits_pkg.sv
// ----------------------------------------------------------------------------
// lits_pkg: shared types and constants for the LCD init table sequencer.
// Holds the beat payloads, the sequencer phase encoding and the fixed
// panel initialisation table.
// ----------------------------------------------------------------------------
package lits_pkg;

  // Input beat: one byte-slot tick.
  typedef struct packed {
    logic start_req;
    logic ms_pulse;
  } tick_t;

  // Output beat: one result per tick.
  typedef struct packed {
    logic       panel_reset_n;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       data_flag;
    logic       done_res;
  } result_t;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RESET = 3'd1,
    PH_CMD   = 3'd2,
    PH_ARGC  = 3'd3,
    PH_DLY   = 3'd4,
    PH_ARGS  = 3'd5,
    PH_WAIT  = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  // Register widths and reset values.
  localparam int unsigned CMD_COUNT_W     = 7;
  localparam int unsigned HOLD_MS_W       = 16;
  localparam logic [CMD_COUNT_W-1:0] CMD_COUNT_RST = 7'd59;
  localparam logic [HOLD_MS_W-1:0]   HOLD_MS_RST   = 16'd5000;

  // Number of used table bytes, and the index width that covers them.
  localparam int unsigned INIT_USED = 328;
  localparam int unsigned INIT_IW   = 9;

  // Panel initialisation records: command, argument count, delay, arguments.
  localparam logic [7:0] INIT_TABLE [INIT_USED] = '{
    8'hFE,8'h00,8'h00, 8'hEF,8'h00,8'h00, 8'hEB,8'h01,8'h00,8'h14,
    8'hFE,8'h00,8'h00, 8'hEF,8'h00,8'h00, 8'hEB,8'h01,8'h00,8'h14,
    8'hFE,8'h00,8'h00, 8'hEF,8'h00,8'h00, 8'hEB,8'h01,8'h00,8'h14,
    8'hFE,8'h00,8'h00, 8'hEF,8'h00,8'h00,
    8'h84,8'h01,8'h00,8'h40, 8'h85,8'h01,8'h00,8'hF1, 8'h86,8'h01,8'h00,8'h98,
    8'h87,8'h01,8'h00,8'h28, 8'h88,8'h01,8'h00,8'h0A, 8'h89,8'h01,8'h00,8'h21,
    8'h8A,8'h01,8'h00,8'h00, 8'h8B,8'h01,8'h00,8'h80, 8'h8C,8'h01,8'h00,8'h01,
    8'h8D,8'h01,8'h00,8'h00, 8'h8E,8'h01,8'h00,8'hDF, 8'h8F,8'h01,8'h00,8'h52,
    8'hB6,8'h01,8'h00,8'h20,
    8'h36,8'h01,8'h00,8'h48,
    8'h3A,8'h01,8'h00,8'h05,
    8'h90,8'h04,8'h00,8'h08,8'h08,8'h08,8'h08,
    8'hBD,8'h01,8'h00,8'h06, 8'hA6,8'h01,8'h00,8'h74, 8'hBF,8'h01,8'h00,8'h1C,
    8'hA7,8'h01,8'h00,8'h45,
    8'hA9,8'h01,8'h00,8'hBB, 8'hB8,8'h01,8'h00,8'h63, 8'hE8,8'h01,8'h00,8'h34,
    8'hFF,8'h03,8'h00,8'h60,8'h01,8'h04,
    8'h74,8'h07,8'h00,8'h10,8'h75,8'h80,8'h00,8'h00,8'h4E,8'h00,
    8'hC3,8'h05,8'h00,8'h14,8'hC4,8'h14,8'hC9,8'h25,
    8'hBE,8'h01,8'h00,8'h11,
    8'hBC,8'h01,8'h00,8'h00,
    8'hE1,8'h02,8'h00,8'h10,8'h0E,
    8'hDF,8'h03,8'h00,8'h21,8'h0C,8'h02,
    8'hED,8'h02,8'h00,8'h1B,8'h0B,
    8'hAE,8'h05,8'h00,8'h77,8'hCB,8'h02,8'hCD,8'h63,
    8'h70,8'h09,8'h00,8'h07,8'h09,8'h04,8'h0E,8'h0F,8'h09,8'h07,8'h08,8'h03,
    8'hF0,8'h06,8'h00,8'h45,8'h09,8'h08,8'h08,8'h26,8'h2A,
    8'hF1,8'h06,8'h00,8'h43,8'h70,8'h72,8'h36,8'h37,8'h6F,
    8'hF2,8'h06,8'h00,8'h45,8'h09,8'h08,8'h08,8'h26,8'h2A,
    8'hF3,8'h06,8'h00,8'h43,8'h70,8'h72,8'h36,8'h37,8'h6F,
    8'h62,8'h0C,8'h00,8'h18,8'h0D,8'h71,8'hED,8'h70,8'h70,8'h18,8'h0F,8'h71,
    8'hEF,8'h70,8'h70,
    8'h63,8'h0C,8'h00,8'h18,8'h11,8'h71,8'hF1,8'h70,8'h70,8'h18,8'h13,8'h71,
    8'hF3,8'h70,8'h70,
    8'h64,8'h07,8'h00,8'h28,8'h29,8'hF1,8'h01,8'hF1,8'h00,8'h07,
    8'h66,8'h0A,8'h00,8'h3C,8'h00,8'hCD,8'h67,8'h45,8'h45,8'h10,8'h00,8'h00,
    8'h00,
    8'h67,8'h0A,8'h00,8'h00,8'h3C,8'h00,8'h00,8'h00,8'h01,8'h54,8'h10,8'h32,
    8'h98,
    8'h74,8'h07,8'h00,8'h10,8'h85,8'h80,8'h00,8'h00,8'h4E,8'h00,
    8'h98,8'h02,8'h00,8'h3E,8'h07,
    8'h35,8'h00,8'h00,
    8'h21,8'h00,8'h00,
    8'h11,8'h00,8'd120,
    8'h29,8'h00,8'd120
  };

endpackage

### rtl/lits_if.sv
// ----------------------------------------------------------------------------
// lits_if: valid/ready channels of the LCD init table sequencer.
// One interface for the tick beats and one for the result beats.
// ----------------------------------------------------------------------------
interface lits_tick_if import lits_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lits_result_if import lits_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/lits_rom.sv
// ----------------------------------------------------------------------------
// lits_rom: initialisation table ROM with a registered read port.
// Addresses at or beyond the used part of the table read as zero.
// ----------------------------------------------------------------------------
module lits_rom
  import lits_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 512
) (
  input  logic                           clk,
  input  logic [$clog2(TABLE_BYTES)-1:0] addr,
  output logic [7:0]                     data
);

  localparam int unsigned AW = $clog2(TABLE_BYTES);

  // Address widened so that it covers both the pointer and the table index.
  logic [AW+INIT_IW-1:0] addr_ext;

  assign addr_ext = {{INIT_IW{1'b0}}, addr};

  // Synchronous read.
  always_ff @(posedge clk) begin
    if (addr_ext < (AW+INIT_IW)'(INIT_USED)) begin
      data <= INIT_TABLE[addr_ext[INIT_IW-1:0]];
    end else begin
      data <= 8'h00;
    end
  end

endmodule

### rtl/lits_out_buf.sv
// ----------------------------------------------------------------------------
// lits_out_buf: result register with a skid stage.
// Holds up to two result beats so that one more tick is taken after the
// receiver stalls.
// ----------------------------------------------------------------------------
module lits_out_buf
  import lits_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  // A new beat is taken whenever the skid stage is free.
  assign can_push = !skid_valid;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

### rtl/lits_core.sv
// ----------------------------------------------------------------------------
// lits_core: sequencer state and the per-tick step logic.
// Each accepted tick advances the sequencer by one step and yields one result.
// ----------------------------------------------------------------------------
module lits_core
  import lits_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  tick_t                          tick_in,
  input  logic [CMD_COUNT_W-1:0]         command_count,
  input  logic [HOLD_MS_W-1:0]           reset_hold_ms,
  output logic [$clog2(TABLE_BYTES)-1:0] rom_addr,
  input  logic [7:0]                     rom_data,
  output result_t                        res
);

  localparam int unsigned AW = $clog2(TABLE_BYTES);
  localparam logic [AW-1:0] PTR_LAST = AW'(TABLE_BYTES - 1);

  phase_t                 phase, phase_next;
  logic [AW-1:0]          table_pointer, table_pointer_next;
  logic [CMD_COUNT_W-1:0] records_left, records_left_next;
  logic [7:0]             args_left, args_left_next;
  logic [7:0]             pending_delay, pending_delay_next;
  logic [HOLD_MS_W-1:0]   ms_left, ms_left_next;
  logic                   reset_line, reset_line_next;

  logic [AW-1:0]          ptr_inc;
  logic [HOLD_MS_W-1:0]   ms_dec;
  logic [CMD_COUNT_W-1:0] records_dec;

  // Helper values used by the phase steps.
  assign ptr_inc     = (table_pointer == PTR_LAST) ? '0 : table_pointer + 1'b1;
  assign ms_dec      = (tick_in.ms_pulse && ms_left != '0) ? ms_left - 1'b1 : ms_left;
  assign records_dec = records_left - 1'b1;

  // The ROM is read ahead, at the pointer the next tick will use.
  assign rom_addr = take ? table_pointer_next : table_pointer;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      table_pointer <= '0;
      records_left  <= '0;
      args_left     <= '0;
      pending_delay <= '0;
      ms_left       <= '0;
      reset_line    <= 1'b1;
    end else if (take) begin
      phase         <= phase_next;
      table_pointer <= table_pointer_next;
      records_left  <= records_left_next;
      args_left     <= args_left_next;
      pending_delay <= pending_delay_next;
      ms_left       <= ms_left_next;
      reset_line    <= reset_line_next;
    end
  end

  // Step logic: next state and the result of this tick.
  always_comb begin
    phase_next         = phase;
    table_pointer_next = table_pointer;
    records_left_next  = records_left;
    args_left_next     = args_left;
    pending_delay_next = pending_delay;
    ms_left_next       = ms_left;
    reset_line_next    = reset_line;
    res                = '0;

    if (tick_in.start_req) begin
      // A start request wins over everything and opens the reset phase.
      phase_next         = PH_RESET;
      reset_line_next    = 1'b0;
      ms_left_next       = reset_hold_ms;
      records_left_next  = command_count;
      table_pointer_next = '0;
      args_left_next     = '0;
      pending_delay_next = '0;
    end else begin
      case (phase)
        PH_RESET: begin
          ms_left_next = ms_dec;
          if (ms_dec == '0) begin
            reset_line_next = 1'b1;
            phase_next      = PH_CMD;
          end
        end
        PH_CMD: begin
          if (records_left == '0) begin
            phase_next = PH_DONE;
          end else begin
            res.byte_valid     = 1'b1;
            res.out_byte       = rom_data;
            table_pointer_next = ptr_inc;
            phase_next         = PH_ARGC;
          end
        end
        PH_ARGC: begin
          args_left_next     = rom_data;
          table_pointer_next = ptr_inc;
          phase_next         = PH_DLY;
        end
        PH_DLY: begin
          pending_delay_next = rom_data;
          table_pointer_next = ptr_inc;
          phase_next         = PH_ARGS;
        end
        PH_ARGS: begin
          if (args_left != '0) begin
            res.byte_valid     = 1'b1;
            res.out_byte       = rom_data;
            res.data_flag      = 1'b1;
            table_pointer_next = ptr_inc;
            args_left_next     = args_left - 1'b1;
          end else begin
            ms_left_next = {{(HOLD_MS_W-8){1'b0}}, pending_delay};
            phase_next   = PH_WAIT;
          end
        end
        PH_WAIT: begin
          ms_left_next = ms_dec;
          if (ms_dec == '0) begin
            records_left_next = records_dec;
            phase_next        = (records_dec == '0) ? PH_DONE : PH_CMD;
          end
        end
        default: begin
        end
      endcase
    end

    res.panel_reset_n = reset_line_next;
    res.done_res      = (phase_next == PH_DONE);
  end

endmodule

### rtl/lcd_init_table_sequencer_unit.sv
// ----------------------------------------------------------------------------
// lcd_init_table_sequencer_unit: power-up command sequencer for an LCD panel.
//
// Each beat on the tick channel is one byte slot of the serial link and may
// carry a millisecond pulse and a start request. Every tick beat gives
// exactly one beat on the result channel: the panel reset line, an optional
// command or argument byte with its data/command flag, and a done flag.
// A start holds the panel in reset for reset_hold_ms pulses, then walks
// command_count records of the built-in table, each followed by its delay.
//
// Throughput is one tick per cycle while the skid stage is empty. A result
// beat is registered in the result register, which is backed by a skid stage:
// one more tick is taken after the receiver stalls, and tick ready then drops
// until it drains. The table ROM is read ahead at the next pointer.
// Reset returns the sequencer to idle with the panel reset line high and
// loads the register defaults (59 records, 5000 ms hold). The registers sit
// on the APB port at byte addresses 0 and 4 and are sampled at each start.
// ----------------------------------------------------------------------------
module lcd_init_table_sequencer_unit
  import lits_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst,
  lits_tick_if.sink          tick,
  lits_result_if.source      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic REG_COMMAND_COUNT = 1'b0;
  localparam logic REG_RESET_HOLD    = 1'b1;

  logic [CMD_COUNT_W-1:0]         command_count;
  logic [HOLD_MS_W-1:0]           reset_hold_ms;
  logic                           cfg_write;
  logic                           take;
  logic                           can_push;
  logic [$clog2(TABLE_BYTES)-1:0] rom_addr;
  logic [7:0]                     rom_data;
  result_t                        step_res;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_count <= CMD_COUNT_RST;
      reset_hold_ms <= HOLD_MS_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_COMMAND_COUNT: command_count <= pwdata[CMD_COUNT_W-1:0];
        REG_RESET_HOLD:    reset_hold_ms <= pwdata[HOLD_MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COMMAND_COUNT: prdata = {{(32-CMD_COUNT_W){1'b0}}, command_count};
      REG_RESET_HOLD:    prdata = {{(32-HOLD_MS_W){1'b0}}, reset_hold_ms};
      default:           prdata = '0;
    endcase
  end

  // Tick handshake.
  assign tick.ready = can_push;
  assign take       = tick.valid && can_push;

  lits_rom #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  lits_core #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .tick_in      (tick.payload),
    .command_count(command_count),
    .reset_hold_ms(reset_hold_ms),
    .rom_addr     (rom_addr),
    .rom_data     (rom_data),
    .res          (step_res)
  );

  lits_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_data(step_res),
    .can_push (can_push),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .out_data (result.payload)
  );

endmodule

### rtl/lits_checker.sv
// ----------------------------------------------------------------------------
// lits_checker: port-level checks for the LCD init table sequencer.
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module lits_checker
  import lits_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res_data
);

  // A stalled result beat stays and keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // No result beat comes out of reset.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat valid straight after reset");

  // Bytes are only sent with the panel out of reset.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.byte_valid |-> res_data.panel_reset_n)
    else $error("byte sent while panel held in reset");

  // A silent slot carries a zero byte and a command flag.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.byte_valid |->
      res_data.out_byte == 8'h00 && !res_data.data_flag)
    else $error("silent slot carries byte data");

  // Once done, nothing is sent and the panel runs.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |->
      !res_data.byte_valid && res_data.panel_reset_n)
    else $error("activity after sequence done");

endmodule

bind lcd_init_table_sequencer_unit lits_checker u_lits_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_data (result.payload)
);

### verif/lits_sequence_checker.sv
// ----------------------------------------------------------------------------
// lits_sequence_checker: result predictor and scoreboard for the LCD init
// table sequencer.
//
// Watches the tick and result channels and the APB register port. Every
// accepted tick is run through a cycle-free model of the sequencer, which
// queues the result beat the block must give for it. Every accepted result
// beat is compared field by field with the oldest queued beat. Register
// writes update the model's copy of the configuration, and register reads
// are compared with that copy.
// ----------------------------------------------------------------------------
module lits_sequence_checker
  import lits_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = 512,
  parameter logic [2:0]  COUNT_ADDR  = 3'd0,
  parameter logic [2:0]  HOLD_ADDR   = 3'd4
) (
  input  logic        clk,
  input  logic        rst,
  lits_tick_if        tick_bus,
  lits_result_if      result_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned beats_compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_MAX = 10;

  // Model copy of the registers and of the sequencer state.
  logic [CMD_COUNT_W-1:0] cfg_count;
  logic [HOLD_MS_W-1:0]   cfg_hold;
  phase_t                 seq_phase;
  int unsigned            rd_ptr;
  logic [6:0]             records_left;
  logic [7:0]             args_left;
  logic [7:0]             record_delay;
  logic [15:0]            ms_left;
  logic                   line_high;

  // Result beats still owed by the block, oldest first.
  result_t exp_panel_beats[$];

  // Count a failure and describe it while the report budget lasts.
  function automatic void flag_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // One ROM read at the table pointer, which then moves on and wraps.
  function automatic logic [7:0] fetch_next();
    logic [7:0] b;
    b = (rd_ptr < INIT_USED && rd_ptr < TABLE_BYTES) ?
        INIT_TABLE[rd_ptr[INIT_IW-1:0]] : 8'h00;
    rd_ptr = (rd_ptr + 1 >= TABLE_BYTES) ? 0 : rd_ptr + 1;
    return b;
  endfunction

  // Advance the model by one tick and work out the result beat it causes.
  task automatic step_panel_sequencer(input tick_t t, output result_t r);
    r = '0;
    if (t.start_req) begin
      // A start wins over everything and latches the registers.
      seq_phase    = PH_RESET;
      line_high    = 1'b0;
      ms_left      = cfg_hold;
      records_left = cfg_count;
      rd_ptr       = 0;
      args_left    = 8'h00;
      record_delay = 8'h00;
    end else begin
      case (seq_phase)
        PH_RESET: begin
          if (t.ms_pulse && ms_left != 0) ms_left = ms_left - 1'b1;
          if (ms_left == 0) begin
            line_high = 1'b1;
            seq_phase = PH_CMD;
          end
        end
        PH_CMD: begin
          if (records_left == 0) begin
            seq_phase = PH_DONE;
          end else begin
            r.byte_valid = 1'b1;
            r.out_byte   = fetch_next();
            r.data_flag  = 1'b0;
            seq_phase    = PH_ARGC;
          end
        end
        PH_ARGC: begin
          args_left = fetch_next();
          seq_phase = PH_DLY;
        end
        PH_DLY: begin
          record_delay = fetch_next();
          seq_phase    = PH_ARGS;
        end
        PH_ARGS: begin
          if (args_left != 0) begin
            r.byte_valid = 1'b1;
            r.out_byte   = fetch_next();
            r.data_flag  = 1'b1;
            args_left    = args_left - 1'b1;
          end else begin
            ms_left   = {8'h00, record_delay};
            seq_phase = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (t.ms_pulse && ms_left != 0) ms_left = ms_left - 1'b1;
          if (ms_left == 0) begin
            records_left = records_left - 1'b1;
            seq_phase    = (records_left == 0) ? PH_DONE : PH_CMD;
          end
        end
        default: begin
        end
      endcase
    end
    r.panel_reset_n = line_high;
    r.done_res      = (seq_phase == PH_DONE);
  endtask

  // Sample every channel at the rising edge, before the block updates.
  always @(posedge clk) begin
    result_t     want;
    result_t     got;
    logic [31:0] reg_val;
    if (rst) begin
      cfg_count    = CMD_COUNT_RST;
      cfg_hold     = HOLD_MS_RST;
      seq_phase    = PH_IDLE;
      rd_ptr       = 0;
      records_left = '0;
      args_left    = '0;
      record_delay = '0;
      ms_left      = '0;
      line_high    = 1'b1;
      exp_panel_beats.delete();
    end else begin
      // Register port: writes update the model, reads are checked.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == COUNT_ADDR) cfg_count = pwdata[CMD_COUNT_W-1:0];
          else if (paddr == HOLD_ADDR) cfg_hold = pwdata[HOLD_MS_W-1:0];
        end else begin
          if (paddr == COUNT_ADDR) reg_val = {25'd0, cfg_count};
          else if (paddr == HOLD_ADDR) reg_val = {16'd0, cfg_hold};
          else reg_val = 32'd0;
          if (prdata !== reg_val) begin
            flag_failure($sformatf("register read at %0d: expected %08h, got %08h",
                                   paddr, reg_val, prdata));
          end
        end
      end

      // Tick beat accepted: queue the beat it must produce.
      if (tick_bus.valid && tick_bus.ready) begin
        step_panel_sequencer(tick_bus.payload, want);
        exp_panel_beats.push_back(want);
      end

      // Result beat accepted: compare with the oldest queued beat.
      if (result_bus.valid && result_bus.ready) begin
        got = result_bus.payload;
        if (exp_panel_beats.size() == 0) begin
          flag_failure($sformatf("result beat with nothing queued: rst_n=%0b vld=%0b",
                                 got.panel_reset_n, got.byte_valid));
        end else begin
          want = exp_panel_beats.pop_front();
          beats_compared++;
          if (got.panel_reset_n !== want.panel_reset_n ||
              got.byte_valid !== want.byte_valid ||
              got.out_byte !== want.out_byte ||
              got.data_flag !== want.data_flag ||
              got.done_res !== want.done_res) begin
            flag_failure($sformatf(
              "beat %0d: expected rst_n=%0b vld=%0b byte=%02h dc=%0b done=%0b, %s",
              beats_compared, want.panel_reset_n, want.byte_valid, want.out_byte,
              want.data_flag, want.done_res,
              $sformatf("got rst_n=%0b vld=%0b byte=%02h dc=%0b done=%0b",
                        got.panel_reset_n, got.byte_valid, got.out_byte,
                        got.data_flag, got.done_res)));
          end
        end
      end
    end
    pending <= exp_panel_beats.size();
  end

endmodule

### verif/lcd_init_table_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// lcd_init_table_sequencer_unit_test: stimulus and verdict for the LCD init
// table sequencer.
//
// Drives tick beats and the APB register port, and throttles the result
// channel. A short directed run covers idle ticks, zero hold and zero
// records, restarts and the ignored pulse on the start tick. It is followed
// by a full table walk under a long result stall, a stretch with no idling
// on either side, and random sequences with random register settings and
// restarts. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module lcd_init_table_sequencer_unit_test;
  import lits_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_BYTES    = 512;
  localparam logic [2:0]  COUNT_ADDR     = 3'd0;
  localparam logic [2:0]  HOLD_ADDR      = 3'd4;
  localparam int unsigned IDLE_PCT       = 36;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned STALL_LIMIT    = 5000;
  localparam int unsigned RANDOM_TICKS   = 80;
  localparam int unsigned MAX_HOLD       = 65535;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lits_tick_if   tick_ch ();
  lits_result_if res_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned beats_compared;

  // Stimulus-side controls and statistics.
  bit          tx_no_idle;
  logic        rx_no_idle;
  int unsigned holdoff_reqs;
  int unsigned ticks_sent;
  int unsigned sequences;
  int unsigned quiet_cycles;

  lcd_init_table_sequencer_unit #(.TABLE_BYTES(TABLE_BYTES)) uut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lits_sequence_checker #(
    .TABLE_BYTES (TABLE_BYTES),
    .COUNT_ADDR  (COUNT_ADDR),
    .HOLD_ADDR   (HOLD_ADDR)
  ) seq_mon (
    .clk            (clk),
    .rst            (rst),
    .tick_bus       (tick_ch),
    .result_bus     (res_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .pending        (pending),
    .beats_compared (beats_compared)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure, which rx_no_idle turns off, and long hold-offs
  // on request from the stimulus.
  initial begin
    int unsigned holdoff_taken;
    holdoff_taken = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_reqs != holdoff_taken) begin
        holdoff_taken++;
        res_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      res_ch.ready <= rx_no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // One APB transfer; the port is left selected so transfers can follow.
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Write both registers, with random junk above the field, and read back.
  task automatic set_registers(input int unsigned records, input int unsigned hold_ms);
    logic [31:0] word;
    word = $urandom();
    word[CMD_COUNT_W-1:0] = records[CMD_COUNT_W-1:0];
    reg_access(1'b1, COUNT_ADDR, word);
    word = $urandom();
    word[HOLD_MS_W-1:0] = hold_ms[HOLD_MS_W-1:0];
    reg_access(1'b1, HOLD_ADDR, word);
    reg_access(1'b0, COUNT_ADDR, 32'd0);
    reg_access(1'b0, HOLD_ADDR, 32'd0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one tick beat, after random idle cycles, and wait for acceptance.
  task automatic send_tick(input logic start, input logic pulse);
    while (!tx_no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid   <= 1'b1;
    tick_ch.payload <= tick_t'{start_req: start, ms_pulse: pulse};
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Stop offering and wait for every queued result to come out. The first
  // edge lets the count take in the tick accepted last.
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A start followed by ticks with random pulses and occasional restarts.
  task automatic run_sequence(input int unsigned records, input int unsigned hold_ms,
                              input int unsigned n_ticks, input int unsigned pulse_pct,
                              input int unsigned restart_pm, input int unsigned holdoff_at);
    wait_drained();
    set_registers(records, hold_ms);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    for (int unsigned i = 1; i < n_ticks; i++) begin
      if (i == holdoff_at) holdoff_reqs <= holdoff_reqs + 1;
      send_tick($urandom_range(0, 999) < restart_pm, $urandom_range(0, 99) < pulse_pct);
    end
    sequences++;
  endtask

  initial begin
    int unsigned random_ticks;
    int unsigned records;
    int unsigned hold_ms;
    int unsigned n_ticks;
    int unsigned pick;

    rst             <= 1'b1;
    tick_ch.valid   <= 1'b0;
    tick_ch.payload <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rx_no_idle      <= 1'b0;
    holdoff_reqs    <= 0;
    tx_no_idle   = 1'b0;
    ticks_sent   = 0;
    sequences    = 0;
    random_ticks = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle before any start: line high, nothing sent, pulses ignored.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    wait_drained();

    // Zero hold and zero records, restarts back to back and during reset.
    set_registers(0, 0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    wait_drained();

    // Short hold: the pulse on the start tick must not count; two records.
    set_registers(2, 2);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (11) send_tick(1'b0, 1'($urandom_range(0, 1)));
    sequences += 3;

    // Full table walk through to done, with the result side held off long
    // enough to stall the tick channel.
    run_sequence(59, 3, 700, 100, 0, 100);

    // A stretch with no idling on either side.
    wait_drained();
    tx_no_idle = 1'b1;
    rx_no_idle <= 1'b1;
    run_sequence(8, 2, 100, 100, 0, 0);
    wait_drained();
    tx_no_idle = 1'b0;
    rx_no_idle <= 1'b0;

    // Random sequences: mostly short tables and holds, some extremes.
    while (random_ticks < RANDOM_TICKS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) records = 0;
      else if (pick < 15) records = 127;
      else if (pick < 25) records = 59;
      else records = $urandom_range(1, 12);
      pick = $urandom_range(0, 99);
      if (pick < 15) hold_ms = 0;
      else if (pick < 20) hold_ms = MAX_HOLD;
      else hold_ms = $urandom_range(1, 8);
      n_ticks = $urandom_range(15, 40);
      run_sequence(records, hold_ms, n_ticks, $urandom_range(20, 100), 8, 0);
      random_ticks += n_ticks;
    end
    wait_drained();

    $display("Run covered %0d ticks in %0d start sequences; %0d result beats compared.",
             ticks_sent, sequences, beats_compared);
    $display("Registers went to both ends, with a long result stall and a stretch at full rate.");
    if (pending != 0) begin
      $display("%0d expected result beats never arrived", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
